### hdl/rgil_pkg.sv
// ----------------------------------------------------------------------------
// rgil_pkg: shared types and constants
// The gamma lookup lanes, the merge stage and the top level use the types and
// constants defined here.
// ----------------------------------------------------------------------------
`default_nettype none

package rgil_pkg;

    // one lane per color channel
    localparam int NUM_LANES = 3;

    // full-scale output code, used as the clip limit
    localparam logic [7:0] CODE_MAX = 8'd255;

    // opcodes carried on the input word
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // per-lane control from the top level
    typedef struct packed {
        logic adv;      // pipeline advances this cycle
        logic wr_en;    // write one knot into the lane's curve copy
    } t_lane_ctl;

    // one corrected pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

`default_nettype wire

### hdl/rgil_lane.sv
// ----------------------------------------------------------------------------
// rgil_lane: one color channel of the gamma lookup
// Holds its own copy of the curve table. Stage 1 reads the two knots around
// the sample, stage 2 blends them by the fraction and clips to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module rgil_lane import rgil_pkg::*; #(
    parameter int PIXEL_BITS  = 12,
    parameter int STEP_BITS   = 6,
    parameter int CURVE_DEPTH = 65,
    localparam int AW         = $clog2(CURVE_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire t_lane_ctl             i_ctl,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [7:0]            i_wr_data,
    input  wire logic [PIXEL_BITS-1:0] i_sample,
    output logic      [7:0]            o_result
);

    localparam int CMP_W = (PIXEL_BITS + 1 > AW) ? PIXEL_BITS + 1 : AW;
    localparam logic [CMP_W-1:0] LAST = CMP_W'(CURVE_DEPTH - 1);
    localparam int SUM_W = STEP_BITS + 10;
    localparam logic [STEP_BITS:0] W_FULL = (STEP_BITS + 1)'(2 ** STEP_BITS);

    logic [7:0]           r_curve [CURVE_DEPTH];
    logic [CMP_W-1:0]     seg_lo;
    logic [CMP_W-1:0]     seg_hi;
    logic [AW-1:0]        addr_lo;
    logic [AW-1:0]        addr_hi;
    logic [7:0]           r_lo;
    logic [7:0]           r_hi;
    logic [STEP_BITS-1:0] r_frac;
    logic [STEP_BITS:0]   w_lo;
    logic [SUM_W-1:0]     blend;
    logic [SUM_W-1:0]     scaled;
    logic [7:0]           r_result;

    // knot addresses, saturated at the last table entry
    assign seg_lo  = CMP_W'(i_sample >> STEP_BITS);
    assign seg_hi  = seg_lo + CMP_W'(1);
    assign addr_lo = (seg_lo > LAST) ? LAST[AW-1:0] : seg_lo[AW-1:0];
    assign addr_hi = (seg_hi > LAST) ? LAST[AW-1:0] : seg_hi[AW-1:0];

    // curve table write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && i_ctl.wr_en) begin
            r_curve[i_wr_addr] <= i_wr_data;
        end
    end

    // stage 1: registered knot reads
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_lo   <= r_curve[addr_lo];
            r_hi   <= r_curve[addr_hi];
            r_frac <= i_sample[STEP_BITS-1:0];
        end
    end

    // stage 2: linear blend, scale back, clip
    assign w_lo   = W_FULL - {1'b0, r_frac};
    assign blend  = SUM_W'(r_lo) * SUM_W'(w_lo) + SUM_W'(r_hi) * SUM_W'(r_frac);
    assign scaled = blend >> STEP_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_result <= (scaled > SUM_W'(CODE_MAX)) ? CODE_MAX : scaled[7:0];
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

### hdl/rgil_merge.sv
// ----------------------------------------------------------------------------
// rgil_merge: lane merge and output buffering
// Gathers the three lane results into one word and holds it in an output
// register backed by a skid register, so the pipeline keeps moving while a
// finished word waits, until the skid register is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module rgil_merge import rgil_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic       i_out_stall,
    output logic            o_valid,
    output t_rgb            o_word,
    output logic            o_full
);

    t_rgb word_in;
    t_rgb r_out;
    t_rgb r_skid;
    t_rgb n_out;
    t_rgb n_skid;
    logic r_out_vld;
    logic r_skid_vld;
    logic n_out_vld;
    logic n_skid_vld;
    logic take;

    assign word_in = '{red: i_red, green: i_green, blue: i_blue};
    assign take    = r_out_vld && !i_out_stall;

    // next-state for output and skid registers
    always_comb begin
        n_out      = r_out;
        n_skid     = r_skid;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            // pipeline is held; drain the skid word first
            if (take) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_vld || take) begin
                n_out     = word_in;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = word_in;
                n_skid_vld = 1'b1;
            end
        end else if (take) begin
            n_out_vld = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;
    assign o_full  = r_skid_vld;

endmodule

`default_nettype wire

### hdl/rgb_gamma_interpolated_lut_unit.sv
// ----------------------------------------------------------------------------
// rgb_gamma_interpolated_lut_unit: piecewise-linear gamma correction for RGB
// A pixel word passes stage 1, stage 2 and the merge output register in order.
// Throughput: one word per cycle, pixel or knot load, while o_in_stall is low;
// each lane's table copy serves its two knot reads per cycle on two read ports.
// Reset clears the pipeline and output valid flags; the curve tables are not
// cleared and must be loaded before pixels are sent.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_gamma_interpolated_lut_unit import rgil_pkg::*; #(
    parameter int PIXEL_BITS  = 12,
    parameter int STEP_BITS   = 6,
    parameter int CURVE_DEPTH = 65,
    localparam int AW         = $clog2(CURVE_DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_opcode,
    input  wire logic [PIXEL_BITS-1:0] i_red_in,
    input  wire logic [PIXEL_BITS-1:0] i_green_in,
    input  wire logic [PIXEL_BITS-1:0] i_blue_in,
    input  wire logic [AW-1:0]         i_knot_index,
    input  wire logic [7:0]            i_knot_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [7:0]            o_red_out,
    output logic      [7:0]            o_green_out,
    output logic      [7:0]            o_blue_out
);

    logic                  full;
    logic                  adv;
    logic                  in_acc;
    logic                  pix_acc;
    logic                  ld_acc;
    logic                  wr_ok;
    logic                  r_s1_vld;
    logic                  r_s2_vld;
    t_lane_ctl             lane_ctl;
    logic [PIXEL_BITS-1:0] samples [NUM_LANES];
    logic [7:0]            results [NUM_LANES];
    t_rgb                  out_word;

    // the pipeline holds only while the skid register is occupied
    assign adv        = !full;
    assign o_in_stall = full;
    assign in_acc     = i_in_valid && adv;
    assign pix_acc    = in_acc && (i_opcode == OP_PIXEL);
    assign wr_ok      = {1'b0, i_knot_index} < (AW + 1)'(CURVE_DEPTH);
    assign ld_acc     = in_acc && (i_opcode == OP_LOAD) && wr_ok;

    assign lane_ctl = '{adv: adv, wr_en: ld_acc};

    assign samples[0] = i_red_in;
    assign samples[1] = i_green_in;
    assign samples[2] = i_blue_in;

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= pix_acc;
            r_s2_vld <= r_s1_vld;
        end
    end

    // one lane per channel, each with its own curve copy
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rgil_lane #(
            .PIXEL_BITS  (PIXEL_BITS),
            .STEP_BITS   (STEP_BITS),
            .CURVE_DEPTH (CURVE_DEPTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_ctl     (lane_ctl),
            .i_wr_addr (i_knot_index),
            .i_wr_data (i_knot_value),
            .i_sample  (samples[g]),
            .o_result  (results[g])
        );
    end

    // merge lane results into the output word
    rgil_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s2_vld && adv),
        .i_red       (results[0]),
        .i_green     (results[1]),
        .i_blue      (results[2]),
        .i_out_stall (i_out_stall),
        .o_valid     (o_out_valid),
        .o_word      (out_word),
        .o_full      (full)
    );

    assign o_red_out   = out_word.red;
    assign o_green_out = out_word.green;
    assign o_blue_out  = out_word.blue;

    // skid word only exists behind a waiting output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid register full while output register empty");

    // an accepted pixel enters stage 1
    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |=> r_s1_vld)
        else $error("accepted pixel lost before stage 1");

    // a knot load makes no result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == OP_LOAD)) |=> !r_s1_vld)
        else $error("knot load produced a pipeline word");

endmodule

`default_nettype wire
